### rtl/xcfp_pkg.sv
// Shared types and constants for the XOR-checked frame parser.
package xcfp_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned KindW  = 2;
	localparam int unsigned CountW = 3;
	localparam int unsigned IndexW = 3;

	// Configuration register indexes
	localparam logic [IndexW-1:0] CFG_START_CODE = 3'd0;
	localparam logic [IndexW-1:0] CFG_HEADER_0   = 3'd1;
	localparam logic [IndexW-1:0] CFG_HDR_COUNT  = 3'd5;
	localparam logic [IndexW-1:0] CFG_MAX_LENGTH = 3'd6;

	localparam logic [ByteW-1:0] START_CODE_RST = 8'h00;
	localparam logic [ByteW-1:0] MAX_LENGTH_RST = 8'd32;
	localparam logic [ByteW-1:0] LEN_ZERO       = 8'h00;
	localparam logic [ByteW-1:0] LEN_INVALID    = 8'hFF;

	// Result kinds
	localparam logic [KindW-1:0] KIND_DATA   = 2'd0;
	localparam logic [KindW-1:0] KIND_ACCEPT = 2'd1;
	localparam logic [KindW-1:0] KIND_REJECT = 2'd2;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HEADER,
		PH_LEN,
		PH_DLEN,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	typedef struct packed {
		logic [ByteW-1:0]  start_code;
		logic [CountW-1:0] header_count;
		logic [ByteW-1:0]  max_length;
	} cfg_t;

endpackage

### rtl/xcfp_cfg_regs.sv
// Configuration register file for the frame parser.
module xcfp_cfg_regs
	import xcfp_pkg::*;
#(
	parameter int unsigned HEADER_SLOTS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IndexW-1:0]   cfg_index,
	input  logic [ByteW-1:0]    cfg_data,
	output cfg_t                cfg,
	output logic [ByteW-1:0]    hdr_codes [HEADER_SLOTS]
);

	cfg_t             cfg_q;
	logic [ByteW-1:0] hdr_code_q [HEADER_SLOTS];
	logic             wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code   <= START_CODE_RST;
			cfg_q.header_count <= '0;
			cfg_q.max_length   <= MAX_LENGTH_RST;
			for (int i = 0; i < HEADER_SLOTS; i++) begin
				hdr_code_q[i] <= '0;
			end
		end else if (wr_en) begin
			case (cfg_index)
				CFG_START_CODE: cfg_q.start_code   <= cfg_data;
				CFG_HDR_COUNT:  cfg_q.header_count <= cfg_data[CountW-1:0];
				CFG_MAX_LENGTH: cfg_q.max_length   <= cfg_data;
				default: begin
					// header code slots; indexes with no slot behind them are dropped
					for (int i = 0; i < HEADER_SLOTS; i++) begin
						if (cfg_index == IndexW'(int'(CFG_HEADER_0) + i)) begin
							hdr_code_q[i] <= cfg_data;
						end
					end
				end
			endcase
		end
	end

	assign cfg       = cfg_q;
	assign hdr_codes = hdr_code_q;

endmodule

### rtl/xcfp_core.sv
// Frame parser datapath: input register, phase machine and result register.
module xcfp_core
	import xcfp_pkg::*;
#(
	parameter int unsigned HEADER_SLOTS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic [ByteW-1:0]  hdr_codes [HEADER_SLOTS],
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ByteW-1:0]  rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KindW-1:0]  kind,
	output logic [ByteW-1:0]  data_byte,
	output logic [ByteW-1:0]  byte_index,
	output logic [ByteW-1:0]  frame_header,
	output logic [ByteW-1:0]  frame_length,
	output logic [ByteW-1:0]  frame_data_length
);

	// input stage
	logic             valid_s1;
	logic [ByteW-1:0] rx_byte_s1;

	// parser state
	phase_t           phase_q, phase_n;
	logic [ByteW-1:0] hdr_q, hdr_n;
	logic [ByteW-1:0] plen_q, plen_n;
	logic [ByteW-1:0] dlen_q, dlen_n;
	logic [ByteW-1:0] xor_q, xor_n;
	logic [ByteW-1:0] pos_q, pos_n;

	// result register
	logic             res_valid_q;
	logic [KindW-1:0] kind_q;
	logic [ByteW-1:0] data_q, idx_q, fhdr_q, flen_q, fdlen_q;

	logic             blocked, fire_s1, emit;
	logic [KindW-1:0] emit_kind;
	logic [ByteW-1:0] emit_idx;
	logic             hdr_hit, len_ok;
	logic [ByteW:0]   pos_next;

	assign blocked  = res_valid_q && out_stall;
	assign fire_s1  = valid_s1 && !blocked;
	assign in_stall = valid_s1 && blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		hdr_hit = 1'b0;
		for (int i = 0; i < HEADER_SLOTS; i++) begin
			if ((CountW'(i) < cfg.header_count) && (hdr_codes[i] == rx_byte_s1)) begin
				hdr_hit = 1'b1;
			end
		end
	end

	assign len_ok   = (rx_byte_s1 != LEN_ZERO) && (rx_byte_s1 != LEN_INVALID) &&
			(rx_byte_s1 <= cfg.max_length);
	assign pos_next = {1'b0, pos_q} + 9'd1;

	always_comb begin
		phase_n   = phase_q;
		hdr_n     = hdr_q;
		plen_n    = plen_q;
		dlen_n    = dlen_q;
		xor_n     = xor_q;
		pos_n     = pos_q;
		emit      = 1'b0;
		emit_kind = KIND_DATA;
		emit_idx  = '0;
		case (phase_q)
			PH_HEADER: begin
				hdr_n   = rx_byte_s1;
				phase_n = hdr_hit ? PH_LEN : PH_HUNT;
			end
			PH_LEN: begin
				plen_n  = rx_byte_s1;
				phase_n = len_ok ? PH_DLEN : PH_HUNT;
			end
			PH_DLEN: begin
				dlen_n = rx_byte_s1;
				if (len_ok) begin
					phase_n = PH_PAYLOAD;
					pos_n   = '0;
				end else begin
					phase_n = PH_HUNT;
				end
			end
			PH_PAYLOAD: begin
				emit      = 1'b1;
				emit_kind = KIND_DATA;
				emit_idx  = pos_q;
				xor_n     = xor_q ^ rx_byte_s1;
				if (pos_next >= {1'b0, plen_q}) begin
					phase_n = PH_CHECK;
					pos_n   = '0;
				end else begin
					pos_n = pos_next[ByteW-1:0];
				end
			end
			PH_CHECK: begin
				emit      = 1'b1;
				emit_kind = (rx_byte_s1 == xor_q) ? KIND_ACCEPT : KIND_REJECT;
				phase_n   = PH_HUNT;
				xor_n     = '0;
				pos_n     = '0;
			end
			default: begin
				phase_n = PH_HUNT;
				if (rx_byte_s1 == cfg.start_code) begin
					phase_n = PH_HEADER;
					xor_n   = '0;
					pos_n   = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			hdr_q   <= '0;
			plen_q  <= '0;
			dlen_q  <= '0;
			xor_q   <= '0;
			pos_q   <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_n;
			hdr_q   <= hdr_n;
			plen_q  <= plen_n;
			dlen_q  <= dlen_n;
			xor_q   <= xor_n;
			pos_q   <= pos_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && emit) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// frame fields are taken before this byte's update, as in the current frame
	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			kind_q  <= emit_kind;
			data_q  <= rx_byte_s1;
			idx_q   <= emit_idx;
			fhdr_q  <= hdr_q;
			flen_q  <= plen_q;
			fdlen_q <= dlen_q;
		end
	end

	assign out_valid         = res_valid_q;
	assign kind              = kind_q;
	assign data_byte         = data_q;
	assign byte_index        = idx_q;
	assign frame_header      = fhdr_q;
	assign frame_length      = flen_q;
	assign frame_data_length = fdlen_q;

endmodule

### rtl/xor_checked_frame_parser.sv
// A result is registered: the input register loads at the transfer of the byte that
// causes it, and the result register loads from it unless a stalled result blocks it.
// Throughput: one byte per cycle; a result held by out_stall holds the input register,
// which then stalls the input until the result transfers.
// Reset (arst_n low): parser returns to hunting, state and result valid clear, registers
// take their reset values (max_length 32, all others 0).
module xor_checked_frame_parser
	import xcfp_pkg::*;
#(
	parameter int unsigned HEADER_SLOTS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IndexW-1:0] cfg_index,
	input  logic [ByteW-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ByteW-1:0]  rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KindW-1:0]  kind,
	output logic [ByteW-1:0]  data_byte,
	output logic [ByteW-1:0]  byte_index,
	output logic [ByteW-1:0]  frame_header,
	output logic [ByteW-1:0]  frame_length,
	output logic [ByteW-1:0]  frame_data_length
);

	cfg_t             cfg;
	logic [ByteW-1:0] hdr_codes [HEADER_SLOTS];

	xcfp_cfg_regs #(
		.HEADER_SLOTS(HEADER_SLOTS)
	) u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg),
		.hdr_codes(hdr_codes)
	);

	xcfp_core #(
		.HEADER_SLOTS(HEADER_SLOTS)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.hdr_codes        (hdr_codes),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.kind             (kind),
		.data_byte        (data_byte),
		.byte_index       (byte_index),
		.frame_header     (frame_header),
		.frame_length     (frame_length),
		.frame_data_length(frame_data_length)
	);

endmodule

### dv/testbench.sv
// Self-checking testbench for the XOR-checked frame parser with a built-in predictor.
`timescale 1ns / 100ps

module testbench;
	import xcfp_pkg::*;

	localparam int unsigned HDR_SLOTS     = 4;
	localparam int unsigned PHASE_ITEMS   = 75;
	localparam int unsigned NUM_PHASES    = 8;
	localparam int unsigned HOLD_CYCLES   = 80;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam logic [IndexW-1:0] CFG_UNUSED = 3'd7;

	// start, header, lengths, payload and check byte of two frames, then two frames with bad lengths
	localparam logic [ByteW-1:0] DIRECTED_BYTES [20] = '{
		8'hA5, 8'hFF, 8'h01, 8'hFE, 8'hA5, 8'hA5,
		8'hA5, 8'h00, 8'h02, 8'h01, 8'hFF, 8'h00, 8'h00,
		8'hA5, 8'h80, 8'hFF,
		8'hA5, 8'h7E, 8'h01, 8'h00
	};

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] value;
		logic [ByteW-1:0] position;
		logic [ByteW-1:0] header;
		logic [ByteW-1:0] pay_len;
		logic [ByteW-1:0] data_len;
	} parse_result_t;

	class parser_scoreboard;
		logic [ByteW-1:0]  start_code;
		logic [ByteW-1:0]  hdr_code [4];
		logic [CountW-1:0] hdr_count;
		logic [ByteW-1:0]  max_len;
		int unsigned       slots;
		phase_t            phase;
		logic [ByteW-1:0]  cur_hdr;
		logic [ByteW-1:0]  cur_len;
		logic [ByteW-1:0]  cur_dlen;
		logic [ByteW-1:0]  xor_acc;
		logic [ByteW-1:0]  pos;
		parse_result_t     expected_results [$];
		int unsigned       errors;

		function new(int unsigned n);
			slots = n;
			start_code = START_CODE_RST;
			foreach (hdr_code[i]) hdr_code[i] = '0;
			hdr_count = '0;
			max_len = MAX_LENGTH_RST;
			phase = PH_HUNT;
			cur_hdr = '0;
			cur_len = '0;
			cur_dlen = '0;
			xor_acc = '0;
			pos = '0;
			errors = 0;
		endfunction

		function void apply_reg(logic [IndexW-1:0] idx, logic [ByteW-1:0] value);
			case (idx)
				CFG_START_CODE: start_code = value;
				CFG_HDR_COUNT:  hdr_count = value[CountW-1:0];
				CFG_MAX_LENGTH: max_len = value;
				default: begin
					if (idx >= CFG_HEADER_0 && idx < CFG_HDR_COUNT)
						hdr_code[idx - CFG_HEADER_0] = value;
				end
			endcase
		endfunction

		function bit header_accepted(logic [ByteW-1:0] h);
			int unsigned n;
			n = (hdr_count > slots) ? slots : hdr_count;
			if (n > 4) n = 4;
			for (int unsigned i = 0; i < n; i++)
				if (hdr_code[i] == h) return 1'b1;
			return 1'b0;
		endfunction

		function bit length_accepted(logic [ByteW-1:0] v);
			return v != LEN_ZERO && v != LEN_INVALID && v <= max_len;
		endfunction

		// Advance the parser by one transferred byte and queue any result it causes.
		function void note_byte(logic [ByteW-1:0] b);
			parse_result_t r;
			case (phase)
				PH_HEADER: begin
					cur_hdr = b;
					phase = header_accepted(b) ? PH_LEN : PH_HUNT;
				end
				PH_LEN: begin
					cur_len = b;
					phase = length_accepted(b) ? PH_DLEN : PH_HUNT;
				end
				PH_DLEN: begin
					cur_dlen = b;
					if (length_accepted(b)) begin
						phase = PH_PAYLOAD;
						pos = '0;
					end else begin
						phase = PH_HUNT;
					end
				end
				PH_PAYLOAD: begin
					xor_acc = xor_acc ^ b;
					r = '{KIND_DATA, b, pos, cur_hdr, cur_len, cur_dlen};
					expected_results.push_back(r);
					if (32'(pos) + 1 >= 32'(cur_len)) begin
						phase = PH_CHECK;
						pos = '0;
					end else begin
						pos = pos + 8'd1;
					end
				end
				PH_CHECK: begin
					r = '{(b == xor_acc) ? KIND_ACCEPT : KIND_REJECT, b, 8'h00,
						cur_hdr, cur_len, cur_dlen};
					expected_results.push_back(r);
					phase = PH_HUNT;
					xor_acc = '0;
					pos = '0;
				end
				default: begin
					phase = PH_HUNT;
					if (b == start_code) begin
						phase = PH_HEADER;
						xor_acc = '0;
						pos = '0;
					end
				end
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(parse_result_t got);
			parse_result_t want;
			if (expected_results.size() == 0) begin
				$error("unexpected result: kind %0d data_byte %0d byte_index %0d",
					got.kind, got.value, got.position);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("data_byte", want.value, got.value);
			compare_field("byte_index", want.position, got.position);
			compare_field("frame_header", want.header, got.header);
			compare_field("frame_length", want.pay_len, got.pay_len);
			compare_field("frame_data_length", want.data_len, got.data_len);
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IndexW-1:0] cfg_index;
	logic [ByteW-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [ByteW-1:0]  rx_byte;
	logic              out_valid;
	logic              out_stall;
	logic [KindW-1:0]  kind;
	logic [ByteW-1:0]  data_byte;
	logic [ByteW-1:0]  byte_index;
	logic [ByteW-1:0]  frame_header;
	logic [ByteW-1:0]  frame_length;
	logic [ByteW-1:0]  frame_data_length;

	parser_scoreboard sb;
	parse_result_t    seen_result;
	bit               calm = 1'b0;
	bit               hold_request = 1'b0;
	int unsigned      items_sent = 0;
	int unsigned      quiet_cycles = 0;

	xor_checked_frame_parser #(.HEADER_SLOTS(HDR_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.frame_header(frame_header),
		.frame_length(frame_length),
		.frame_data_length(frame_data_length)
	);

	always #2 clk = ~clk;

	// Sample every transfer at the rising edge, before any register of the block updates.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen_result = '{kind, data_byte, byte_index, frame_header, frame_length,
					frame_data_length};
				sb.check_result(seen_result);
			end
			if (in_valid && !in_stall)
				sb.note_byte(rx_byte);
			if (cfg_valid && cfg_ready)
				sb.apply_reg(cfg_index, cfg_data);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$error("no transfer for %0d cycles", quiet_cycles);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	// Result side: random stalls, one long hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= !calm && ($urandom_range(99) < 36);
		end
	end

	task automatic send_byte(input logic [ByteW-1:0] value);
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= value;
		do @(posedge clk); while (in_stall);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [IndexW-1:0] idx, input logic [ByteW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [ByteW-1:0] start, input logic [ByteW-1:0] h0,
			input logic [ByteW-1:0] h1, input logic [ByteW-1:0] h2,
			input logic [ByteW-1:0] h3, input logic [CountW-1:0] count,
			input logic [ByteW-1:0] maxl, input bit poke_unused);
		cfg_write(CFG_START_CODE, start);
		cfg_write(CFG_HEADER_0, h0);
		cfg_write(CFG_HEADER_0 + 3'd1, h1);
		cfg_write(CFG_HEADER_0 + 3'd2, h2);
		cfg_write(CFG_HEADER_0 + 3'd3, h3);
		cfg_write(CFG_HDR_COUNT, {5'd0, count});
		cfg_write(CFG_MAX_LENGTH, maxl);
		if (poke_unused)
			cfg_write(CFG_UNUSED, 8'hFF);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every expected result, then let the pipeline empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic int unsigned good_length(int unsigned lim, int unsigned one_in);
		if (lim == 0) return $urandom_range(1, 8);
		if ($urandom_range(one_in - 1) == 0) return lim;
		return $urandom_range(1, (lim < 8) ? lim : 8);
	endfunction

	function automatic int unsigned bad_length(int unsigned lim);
		case ($urandom_range(2))
			0: return LEN_ZERO;
			1: return LEN_INVALID;
			default: return (lim < 254) ? $urandom_range(lim + 1, 254) : LEN_ZERO;
		endcase
	endfunction

	// One chunk of traffic: mostly well-formed frames, some noise and broken frames.
	task automatic send_traffic();
		int unsigned      pick;
		int unsigned      lim;
		int unsigned      slots;
		int unsigned      len;
		int unsigned      dlen;
		int unsigned      body;
		int unsigned      i;
		logic [ByteW-1:0] hdr;
		logic [ByteW-1:0] acc;
		logic [ByteW-1:0] b;
		pick  = $urandom_range(99);
		lim   = (sb.max_len == LEN_INVALID) ? 254 : sb.max_len;
		slots = (sb.hdr_count > HDR_SLOTS) ? HDR_SLOTS : sb.hdr_count;
		if (pick < 12) begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
			return;
		end
		if (slots == 0 || pick < 20)
			hdr = 8'($urandom_range(255));
		else
			hdr = sb.hdr_code[$urandom_range(slots - 1)];
		len  = (pick >= 20 && pick < 24) ? bad_length(lim) : good_length(lim, 25);
		dlen = (pick >= 24 && pick < 28) ? bad_length(lim) : good_length(lim, 4);
		send_byte(sb.start_code);
		send_byte(hdr);
		send_byte(8'(len));
		send_byte(8'(dlen));
		if (pick < 28) return;
		// truncate now and then so the next frame runs into the payload
		body = (pick < 32) ? $urandom_range(0, len - 1) : len;
		acc = 8'h00;
		for (i = 0; i < body; i++) begin
			b = 8'($urandom_range(255));
			acc = acc ^ b;
			send_byte(b);
		end
		if (body < len) return;
		if ($urandom_range(5) == 0) acc = acc ^ 8'($urandom_range(1, 255));
		send_byte(acc);
	endtask

	initial begin
		logic [CountW-1:0] count;
		logic [ByteW-1:0]  maxl;
		logic [ByteW-1:0]  start;
		int unsigned       phase_start;
		bit                hold_done;
		sb = new(HDR_SLOTS);
		hold_done = 1'b0;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		rx_byte   = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: no header slot in use, so this frame is dropped
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h01);
		send_byte(8'h01);
		settle();

		program_regs(8'hA5, 8'h00, 8'h80, 8'hFF, 8'h7E, 3'd4, 8'd254, 1'b1);
		foreach (DIRECTED_BYTES[k]) send_byte(DIRECTED_BYTES[k]);
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			start = 8'($urandom_range(255));
			case (p)
				0: begin count = 3'd4; maxl = 8'd254; start = 8'h00; end
				1: begin count = 3'd1; maxl = 8'd8;   start = 8'hFF; end
				2: begin count = 3'd7; maxl = 8'hFF; end
				3: begin count = 3'd2; maxl = 8'd1;  end
				4: begin count = 3'd0; maxl = 8'd16; end
				5: begin count = 3'd3; maxl = 8'd0;  end
				default: begin
					count = 3'(p - 1);
					maxl  = 8'($urandom_range(2, 254));
				end
			endcase
			program_regs(start, 8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'($urandom_range(255)), count, maxl, 1'b0);
			calm = (p == 2);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				// hold the result side off once while bytes keep coming
				if (p == 0 && !hold_done && items_sent - phase_start >= 20) begin
					hold_request = 1'b1;
					hold_done    = 1'b1;
				end
				send_traffic();
			end
			settle();
			calm = 1'b0;
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

### files.f
rtl/xcfp_pkg.sv
rtl/xcfp_cfg_regs.sv
rtl/xcfp_core.sv
rtl/xor_checked_frame_parser.sv
dv/testbench.sv
